>>> hdl/ucrr_pkg.sv
// shared types, codes and constants of the usb control request responder
`default_nettype none

package ucrr_pkg;

    // default sizes
    localparam int PACKET_SIZE_DEF  = 64;
    localparam int STRING_SLOTS_DEF = 4;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int STRING_REGS = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CONFIGURATIONS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_TOTAL_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_COUNT        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_LENGTH_0     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_LENGTH_1     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_LENGTH_2     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_LENGTH_3     = 3'd6;

    // event kinds
    localparam logic [1:0] CMD_BUS_RESET   = 2'd0;
    localparam logic [1:0] CMD_STALL       = 2'd1;
    localparam logic [1:0] CMD_TRANSACTION = 2'd2;

    // packet identifiers
    localparam logic [3:0] PID_OUT   = 4'h1;
    localparam logic [3:0] PID_ACK   = 4'h2;
    localparam logic [3:0] PID_SETUP = 4'hD;

    localparam logic [7:0] TYPE_MASK = 8'h60;

    // standard request codes
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

    // descriptor types
    localparam logic [7:0] DESC_DEVICE    = 8'd1;
    localparam logic [7:0] DESC_CONFIG    = 8'd2;
    localparam logic [7:0] DESC_STRING    = 8'd3;
    localparam logic [7:0] DESC_QUALIFIER = 8'd6;

    localparam logic [6:0] DEVICE_DESC_SIZE = 7'd18;
    localparam logic [6:0] CONFIG_DESC_SIZE = 7'd9;

    typedef enum logic [3:0] {
        ACT_NONE         = 4'd0,
        ACT_SEND_IN      = 4'd1,
        ACT_STALL_IN     = 4'd2,
        ACT_FWD_OUT      = 4'd3,
        ACT_FWD_SETUP    = 4'd4,
        ACT_IN_CALLBACK  = 4'd5,
        ACT_ADDR_APPLIED = 4'd6,
        ACT_CLEAR_STALL  = 4'd7,
        ACT_RESET_SEEN   = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        SRC_ZERO_LENGTH = 2'd0,
        SRC_DEVICE      = 2'd1,
        SRC_CONFIG      = 2'd2,
        SRC_STRING      = 2'd3
    } source_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  endpoint;
        logic        is_in;
        logic [3:0]  pid;
        logic [6:0]  byte_count;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } evt_t;

    typedef struct packed {
        action_t     action;
        logic [3:0]  target_endpoint;
        logic [6:0]  in_length;
        source_t     source;
        logic [7:0]  source_index;
        logic [6:0]  new_address;
        logic        rearm_control_out;
        logic        resume_packets;
        logic [6:0]  forward_size;
    } res_t;

    typedef struct packed {
        logic [7:0]                  num_configurations;
        logic [15:0]                 config_total_length;
        logic [2:0]                  string_count;
        logic [STRING_REGS-1:0][7:0] string_length;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/ucrr_cfg.sv
// configuration register bank
`default_nettype none

module ucrr_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [ucrr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ucrr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ucrr_pkg::cfg_t                        cfg
);

    ucrr_pkg::cfg_t cfg_reg;
    ucrr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ucrr_pkg::CFG_NUM_CONFIGURATIONS:  cfg_next.num_configurations = cfg_data[7:0];
                ucrr_pkg::CFG_CONFIG_TOTAL_LENGTH: cfg_next.config_total_length = cfg_data;
                ucrr_pkg::CFG_STRING_COUNT:        cfg_next.string_count = cfg_data[2:0];
                ucrr_pkg::CFG_STRING_LENGTH_0:     cfg_next.string_length[0] = cfg_data[7:0];
                ucrr_pkg::CFG_STRING_LENGTH_1:     cfg_next.string_length[1] = cfg_data[7:0];
                ucrr_pkg::CFG_STRING_LENGTH_2:     cfg_next.string_length[2] = cfg_data[7:0];
                ucrr_pkg::CFG_STRING_LENGTH_3:     cfg_next.string_length[3] = cfg_data[7:0];
                default:                           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_configurations  <= 8'd1;
            cfg_reg.config_total_length <= 16'd9;
            cfg_reg.string_count        <= 3'd0;
            cfg_reg.string_length       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hdl/ucrr_decode.sv
// request decode, length clamps and the pending device address
`default_nettype none

module ucrr_decode #(
    parameter int PACKET_SIZE  = ucrr_pkg::PACKET_SIZE_DEF,
    parameter int STRING_SLOTS = ucrr_pkg::STRING_SLOTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire ucrr_pkg::evt_t item,
    input  wire ucrr_pkg::cfg_t cfg,
    output ucrr_pkg::res_t      result
);

    localparam logic [6:0]  PS7  = 7'(PACKET_SIZE);
    localparam logic [15:0] PS16 = 16'(PACKET_SIZE);
    localparam logic [7:0]  SLOTS8 = 8'(STRING_SLOTS);

    logic [6:0] pend_reg;
    logic [6:0] pend_next;

    logic [6:0] fsize;
    logic [6:0] wlen_clamp;
    logic [6:0] dev_len;
    logic [6:0] cfg_len;
    logic [7:0] str_sel;
    logic [6:0] str_len;
    logic [7:0] didx;
    logic [7:0] dtype;
    logic       cfg_ok;
    logic       str_ok;

    assign didx  = item.request_value[7:0];
    assign dtype = item.request_value[15:8];

    assign fsize      = (item.byte_count > PS7) ? PS7 : item.byte_count;
    assign wlen_clamp = (item.request_length < PS16) ? item.request_length[6:0] : PS7;
    assign dev_len    = (wlen_clamp < ucrr_pkg::DEVICE_DESC_SIZE) ? wlen_clamp
                                                                  : ucrr_pkg::DEVICE_DESC_SIZE;
    // long requests are cut to the total length of the configuration set
    assign cfg_len = (wlen_clamp > ucrr_pkg::CONFIG_DESC_SIZE &&
                      cfg.config_total_length < {9'd0, wlen_clamp})
                     ? cfg.config_total_length[6:0] : wlen_clamp;
    assign str_sel = cfg.string_length[didx[1:0]];
    assign str_len = ({1'b0, wlen_clamp} < str_sel) ? wlen_clamp : str_sel[6:0];
    assign cfg_ok  = (cfg.num_configurations != 8'd0) && (didx < cfg.num_configurations);
    assign str_ok  = (didx < {5'd0, cfg.string_count}) && (didx < SLOTS8);

    always_comb
    begin
        result    = '0;
        pend_next = pend_reg;
        case (item.cmd)
            ucrr_pkg::CMD_BUS_RESET:
            begin
                result.action          = ucrr_pkg::ACT_RESET_SEEN;
                result.target_endpoint = item.endpoint;
            end
            ucrr_pkg::CMD_STALL:
            begin
                result.action          = ucrr_pkg::ACT_CLEAR_STALL;
                result.target_endpoint = item.endpoint;
            end
            ucrr_pkg::CMD_TRANSACTION:
            begin
                if (item.is_in)
                begin
                    result.target_endpoint = item.endpoint;
                    if (pend_reg != 7'd0)
                    begin
                        result.action      = ucrr_pkg::ACT_ADDR_APPLIED;
                        result.new_address = pend_reg;
                        pend_next          = 7'd0;
                    end
                    else
                    begin
                        result.action = ucrr_pkg::ACT_IN_CALLBACK;
                    end
                end
                else if (item.pid == ucrr_pkg::PID_OUT)
                begin
                    result.action          = ucrr_pkg::ACT_FWD_OUT;
                    result.target_endpoint = item.endpoint;
                    result.forward_size    = fsize;
                end
                else if (item.pid == ucrr_pkg::PID_SETUP)
                begin
                    result.resume_packets = 1'b1;
                    if ((item.request_type & ucrr_pkg::TYPE_MASK) != 8'd0)
                    begin
                        result.action          = ucrr_pkg::ACT_FWD_SETUP;
                        result.target_endpoint = item.endpoint;
                        result.forward_size    = fsize;
                    end
                    else if (item.request_code inside {ucrr_pkg::REQ_SET_ADDRESS,
                                                       ucrr_pkg::REQ_SET_CONFIGURATION})
                    begin
                        if (item.request_code == ucrr_pkg::REQ_SET_ADDRESS)
                        begin
                            pend_next = item.request_value[6:0];
                        end
                        result.action            = ucrr_pkg::ACT_SEND_IN;
                        result.rearm_control_out = 1'b1;
                    end
                    else if (item.request_code == ucrr_pkg::REQ_GET_DESCRIPTOR)
                    begin
                        case (dtype)
                            ucrr_pkg::DESC_DEVICE:
                            begin
                                result.action            = ucrr_pkg::ACT_SEND_IN;
                                result.source            = ucrr_pkg::SRC_DEVICE;
                                result.in_length         = dev_len;
                                result.rearm_control_out = 1'b1;
                            end
                            ucrr_pkg::DESC_CONFIG:
                            begin
                                result.rearm_control_out = 1'b1;
                                if (cfg_ok)
                                begin
                                    result.action       = ucrr_pkg::ACT_SEND_IN;
                                    result.source       = ucrr_pkg::SRC_CONFIG;
                                    result.source_index = didx;
                                    result.in_length    = cfg_len;
                                end
                            end
                            ucrr_pkg::DESC_STRING:
                            begin
                                result.rearm_control_out = 1'b1;
                                if (str_ok)
                                begin
                                    result.action       = ucrr_pkg::ACT_SEND_IN;
                                    result.source       = ucrr_pkg::SRC_STRING;
                                    result.source_index = didx;
                                    result.in_length    = str_len;
                                end
                            end
                            ucrr_pkg::DESC_QUALIFIER:
                            begin
                                result.action            = ucrr_pkg::ACT_STALL_IN;
                                result.rearm_control_out = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 7'd0;
        end
        else if (adv)
        begin
            pend_reg <= pend_next;
        end
    end

    // an applied address is consumed
    a_pend_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        adv && item.cmd == ucrr_pkg::CMD_TRANSACTION && item.is_in && pend_reg != 7'd0
        |=> pend_reg == 7'd0)
        else $error("pending address not cleared after being applied");

    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pend_reg))
        else $error("pending address changed without a transaction");

    a_addr_applied: assert property (@(posedge clk) disable iff (!rst_n)
        adv && result.action == ucrr_pkg::ACT_ADDR_APPLIED
        |-> result.new_address == pend_reg && pend_reg != 7'd0)
        else $error("address applied without a pending address");

endmodule

`default_nettype wire

>>> hdl/usb_control_request_responder_unit.sv
// top level of the usb control request responder: input register, decode, result register
//
// channel  | handshake             | payload
// evt      | evt_valid / evt_stall | ucrr_pkg::evt_t, one device event
// res      | res_valid / res_stall | ucrr_pkg::res_t, one reply per event
// cfg      | cfg_write             | cfg_index, cfg_data
//
// one event per cycle unless stalled; a result is registered once its event is decoded
// the rate is set by the single decode stage between the input and result registers
// reset clears both stage valids and the pending address, and loads register defaults
// a stalled result holds; evt_stall rises only when both stages are full
`default_nettype none

module usb_control_request_responder_unit #(
    parameter int PACKET_SIZE  = ucrr_pkg::PACKET_SIZE_DEF,
    parameter int STRING_SLOTS = ucrr_pkg::STRING_SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             evt_valid,
    output      logic                             evt_stall,
    input  wire ucrr_pkg::evt_t                   evt,
    output      logic                             res_valid,
    input  wire logic                             res_stall,
    output ucrr_pkg::res_t                        res,
    input  wire logic                             cfg_write,
    input  wire logic [ucrr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ucrr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ucrr_pkg::cfg_t cfg;
    ucrr_pkg::res_t dec_result;

    logic           s1_valid_reg;
    logic           s1_valid_next;
    ucrr_pkg::evt_t s1_item_reg;
    ucrr_pkg::evt_t s1_item_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    ucrr_pkg::res_t out_item_reg;
    ucrr_pkg::res_t out_item_next;

    logic out_free;
    logic s1_adv;
    logic evt_take;

    ucrr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ucrr_decode #(
        .PACKET_SIZE  (PACKET_SIZE),
        .STRING_SLOTS (STRING_SLOTS)
    ) u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (s1_adv),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (dec_result)
    );

    assign out_free  = !out_valid_reg || !res_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign evt_stall = s1_valid_reg && !out_free;
    assign evt_take  = evt_valid && !evt_stall;

    always_comb
    begin
        s1_valid_next  = evt_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s1_item_next   = evt_take ? evt : s1_item_reg;
        out_valid_next = s1_adv ? 1'b1 : (res_stall ? out_valid_reg : 1'b0);
        out_item_next  = s1_adv ? dec_result : out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= s1_item_next;
        out_item_reg <= out_item_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_item_reg;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        evt_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> res_valid)
        else $error("decoded transaction lost on the way to the result register");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.in_length <= 7'(PACKET_SIZE) && res.forward_size <= 7'(PACKET_SIZE))
        else $error("length above packet size");

endmodule

`default_nettype wire
